### rtl/core/oll_pkg.sv
// shared types and constants for the ordered list block
package oll_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		FN_APPEND   = 2'd0,
		FN_DELETE   = 2'd1,
		FN_DUMP_FWD = 2'd2,
		FN_DUMP_BWD = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_ENTRY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_SHIFT,
		S_DUMP,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RD_START,
		RD_CUR,
		RD_NEXT,
		RD_NEXT2
	} rd_sel_t;

	typedef struct packed {
		logic    req_ready;
		logic    idx_inc;
		logic    wr_en;
		logic    cnt_inc;
		logic    cnt_dec;
		rd_sel_t rd_sel;
		logic    out_load;
		logic    out_dump;
		logic    out_last;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic             req_valid;
		func_t            func;
		logic             full;
		logic             empty;
		logic             match;
		logic             at_last;
		logic             shift_more;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} sts_t;

endpackage

### rtl/core/oll_req_if.sv
// request channel: operation and value
interface oll_req_if;
	logic                             valid;
	logic                             ready;
	oll_pkg::func_t                   func;
	logic signed [oll_pkg::VAL_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

### rtl/core/oll_rsp_if.sv
// response channel: status, entry value and last marker
interface oll_rsp_if;
	logic                             valid;
	logic                             ready;
	oll_pkg::status_t                 status;
	logic signed [oll_pkg::VAL_W-1:0] item_value;
	logic                             last;

	modport source (output valid, output status, output item_value, output last, input ready);
	modport sink   (input valid, input status, input item_value, input last, output ready);
endinterface

### rtl/core/oll_ram.sv
// generic single write port ram with registered read
module oll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/oll_ctrl.sv
// controller state machine for the ordered list
module oll_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  oll_pkg::sts_t sts,
	output oll_pkg::cmd_t cmd
);

	oll_pkg::state_t  state_q, state_d;
	oll_pkg::status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oll_pkg::S_IDLE;
			res_q   <= oll_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			oll_pkg::S_IDLE: begin
				cmd.req_ready = 1'b1;
				if (sts.req_valid) begin
					state_d = oll_pkg::S_DECODE;
				end
			end
			oll_pkg::S_DECODE: begin
				case (sts.func)
					oll_pkg::FN_APPEND: begin
						state_d = oll_pkg::S_EMIT;
						if (sts.full) begin
							res_d = oll_pkg::ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.cnt_inc = 1'b1;
							res_d       = oll_pkg::ST_DONE;
						end
					end
					oll_pkg::FN_DELETE: begin
						if (sts.empty) begin
							res_d   = oll_pkg::ST_NOT_FOUND;
							state_d = oll_pkg::S_EMIT;
						end else begin
							cmd.rd_sel = oll_pkg::RD_START;
							state_d    = oll_pkg::S_SEARCH;
						end
					end
					default: begin
						if (sts.empty) begin
							res_d   = oll_pkg::ST_EMPTY;
							state_d = oll_pkg::S_EMIT;
						end else begin
							cmd.rd_sel = oll_pkg::RD_START;
							state_d    = oll_pkg::S_DUMP;
						end
					end
				endcase
			end
			oll_pkg::S_SEARCH: begin
				if (sts.match) begin
					if (sts.at_last) begin
						cmd.cnt_dec = 1'b1;
						res_d       = oll_pkg::ST_DONE;
						state_d     = oll_pkg::S_EMIT;
					end else begin
						cmd.rd_sel = oll_pkg::RD_NEXT;
						state_d    = oll_pkg::S_SHIFT;
					end
				end else if (sts.at_last) begin
					res_d   = oll_pkg::ST_NOT_FOUND;
					state_d = oll_pkg::S_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.rd_sel  = oll_pkg::RD_NEXT;
				end
			end
			oll_pkg::S_SHIFT: begin
				cmd.wr_en = 1'b1;
				if (sts.shift_more) begin
					cmd.rd_sel  = oll_pkg::RD_NEXT2;
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					res_d       = oll_pkg::ST_DONE;
					state_d     = oll_pkg::S_EMIT;
				end
			end
			oll_pkg::S_DUMP: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_dump   = 1'b1;
					cmd.out_status = oll_pkg::ST_ENTRY;
					cmd.out_last   = sts.at_last;
					if (sts.at_last) begin
						state_d = oll_pkg::S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						cmd.rd_sel  = oll_pkg::RD_NEXT;
					end
				end else begin
					cmd.rd_sel = oll_pkg::RD_CUR;
				end
			end
			oll_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = res_q;
					cmd.out_last   = 1'b1;
					state_d        = oll_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = oll_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/oll_dp.sv
// datapath: entry store, count, walk index and output register
module oll_dp (
	input  logic          clk,
	input  logic          arst_n,
	oll_req_if.sink       req,
	oll_rsp_if.source     rsp,
	input  oll_pkg::cmd_t cmd,
	output oll_pkg::sts_t sts
);

	localparam int IW = oll_pkg::IDX_W;
	localparam int CW = oll_pkg::CNT_W;
	localparam int KW = oll_pkg::CNT_W + 1;

	logic [IW-1:0]                    idx_q;
	logic [CW-1:0]                    count_q;
	oll_pkg::func_t                   func_q;
	logic [oll_pkg::VAL_W-1:0]        value_q;
	logic                             out_valid_q;
	oll_pkg::status_t                 out_status_q;
	logic [oll_pkg::VAL_W-1:0]        out_value_q;
	logic                             out_last_q;
	logic [oll_pkg::VAL_W-1:0]        rdata;
	logic [IW-1:0]                    raddr;
	logic [IW-1:0]                    waddr;
	logic [oll_pkg::VAL_W-1:0]        wdata;
	logic [KW-1:0]                    k;
	logic [KW-1:0]                    cnt_ext;
	logic [KW-1:0]                    idx_ext;
	logic                             bwd;
	logic                             accept;
	logic                             out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign bwd      = (func_q == oll_pkg::FN_DUMP_BWD);
	assign cnt_ext  = KW'(count_q);
	assign idx_ext  = KW'(idx_q);

	always_comb begin
		case (cmd.rd_sel)
			oll_pkg::RD_START: k = '0;
			oll_pkg::RD_CUR:   k = idx_ext;
			oll_pkg::RD_NEXT:  k = idx_ext + KW'(1);
			oll_pkg::RD_NEXT2: k = idx_ext + KW'(2);
			default:           k = '0;
		endcase
		if (bwd) begin
			raddr = IW'(cnt_ext - KW'(1) - k);
		end else begin
			raddr = IW'(k);
		end
	end

	assign waddr = cmd.cnt_inc ? IW'(count_q) : idx_q;
	assign wdata = cmd.cnt_inc ? value_q : rdata;

	oll_ram #(
		.WIDTH (oll_pkg::VAL_W),
		.DEPTH (oll_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_value_q  <= cmd.out_dump ? rdata : '0;
			out_last_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready      = cmd.req_ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.item_value = out_value_q;
	assign rsp.last       = out_last_q;

	assign sts.req_valid  = req.valid;
	assign sts.func       = func_q;
	assign sts.full       = (count_q == CW'(oll_pkg::CAPACITY));
	assign sts.empty      = (count_q == '0);
	assign sts.match      = (rdata == value_q);
	assign sts.at_last    = (idx_ext + KW'(1) == cnt_ext);
	assign sts.shift_more = (idx_ext + KW'(2) < cnt_ext);
	assign sts.out_free   = out_free;
	assign sts.count      = count_q;

endmodule

### rtl/core/ordered_list_append_delete.sv
// top level of the bounded ordered list with append, delete and dumps
//
//  channel  dir  fields                     per transfer
//  req      in   func, value                one operation
//  rsp      out  status, item_value, last   one result, last marks the final one
//
// append, full list and empty cases: result from the decode state, then the emit state loads the output register
// delete: walks the single-read-port entry ram to find the value, then shifts the later entries down
// dumps: one result per cycle while rsp is ready, entry count results
// reset clears the count and control; entry storage needs no clearing pass
// a stalled rsp holds the walk; the next request is taken once the last result is loaded
module ordered_list_append_delete (
	input  logic      clk,
	input  logic      arst_n,
	oll_req_if.sink   req,
	oll_rsp_if.source rsp
);

	oll_pkg::cmd_t cmd;
	oll_pkg::sts_t sts;

	oll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	oll_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= oll_pkg::CNT_W'(oll_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while held");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sts.count) |->
			(sts.count == $past(sts.count) + oll_pkg::CNT_W'(1)) ||
			(sts.count == $past(sts.count) - oll_pkg::CNT_W'(1)))
		else $error("entry count jumped");
`endif

endmodule

### sim/ordered_list_append_delete_tb.sv
// testbench for the ordered list: directed and random append, delete and dump traffic
`timescale 1ns / 1ps

module ordered_list_append_delete_tb;
	import oll_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 85;
	localparam int MAX_PRINTED  = 30;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] item_value;
		logic                    last;
	} list_result_t;

	logic clk;
	logic arst_n;

	oll_req_if req_if ();
	oll_rsp_if rsp_if ();

	ordered_list_append_delete u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	logic signed [VAL_W-1:0] list_contents[$];
	list_result_t            pending_results[$];
	int unsigned             error_count;
	int unsigned             cycle_count;
	int unsigned             burst_left;
	int unsigned             stall_left;
	int unsigned             stall_phase_cnt;
	int unsigned             stall_mode;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_list_append_delete_tb: FAIL");
			$finish;
		end
	end

	// expected results of one operation, and the list after it
	function automatic void apply_list_op(func_t op, logic signed [VAL_W-1:0] val);
		list_result_t r;
		int           hit;
		int           n;
		n   = list_contents.size();
		hit = -1;
		r.item_value = '0;
		r.last       = 1'b1;
		case (op)
			FN_APPEND: begin
				if (n >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_contents.push_back(val);
					r.status = ST_DONE;
				end
				pending_results.push_back(r);
			end
			FN_DELETE: begin
				for (int i = 0; i < n; i++) begin
					if (hit < 0 && list_contents[i] == val) hit = i;
				end
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					list_contents.delete(hit);
					r.status = ST_DONE;
				end
				pending_results.push_back(r);
			end
			default: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
					pending_results.push_back(r);
				end else begin
					for (int i = 0; i < n; i++) begin
						r.status     = ST_ENTRY;
						r.item_value = (op == FN_DUMP_FWD) ? list_contents[i]
							: list_contents[n-1-i];
						r.last       = (i == n - 1);
						pending_results.push_back(r);
					end
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d value %0d",
					rsp_if.status, rsp_if.item_value));
			end else begin
				e = pending_results.pop_front();
				if (rsp_if.status !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_if.status, e.status));
				if (rsp_if.item_value !== e.item_value)
					report_mismatch($sformatf("item_value %0d, expected %0d",
						rsp_if.item_value, e.item_value));
				if (rsp_if.last !== e.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						rsp_if.last, e.last));
			end
		end
	end

	// receiver stall pattern, with the stall mode picked at random at the end of each phase
	always @(posedge clk) begin
		stall_phase_cnt++;
		if (stall_phase_cnt >= 150) begin
			stall_phase_cnt = 0;
			stall_mode      = $urandom_range(0, 2);
		end
		if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_if.ready <= 1'b1;
			case (stall_mode)
				1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
				2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 12);
				default: ;
			endcase
		end
	end

	// one request transfer, with the sender's bursts and gaps
	task automatic send_op(func_t op, logic signed [VAL_W-1:0] val);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.func  <= op;
		req_if.value <= val;
		do @(posedge clk); while (!req_if.ready);
		apply_list_op(op, val);
	endtask

	task automatic wait_list_idle();
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return int'($urandom_range(0, 6)) - 3;
			default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		endcase
	endfunction

	task automatic test_empty_list();
		send_op(FN_DUMP_FWD, 32'sh7fff_ffff);
		send_op(FN_DUMP_BWD, 32'sh8000_0000);
		send_op(FN_DELETE, 32'sd0);
	endtask

	task automatic test_fill_to_capacity();
		logic signed [VAL_W-1:0] fill[16];
		fill = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sd42, -32'sd42, 32'sd5, 32'sd123456,
			-32'sd7, 32'sh0000_ffff, 32'shffff_0000};
		for (int i = 0; i < CAPACITY; i++) send_op(FN_APPEND, fill[i % 16]);
		send_op(FN_APPEND, 32'sd99);
	endtask

	task automatic test_dump_both_ways();
		send_op(FN_DUMP_FWD, $urandom);
		send_op(FN_DUMP_BWD, $urandom);
	endtask

	task automatic test_delete_cases();
		// duplicates: the one nearest the head goes first
		send_op(FN_DELETE, 32'sd5);
		send_op(FN_DELETE, 32'sd77);
		send_op(FN_DUMP_FWD, 32'sd0);
	endtask

	task automatic test_random_ops();
		bit                      grow;
		int unsigned             r;
		logic signed [VAL_W-1:0] val;
		grow = 1'b0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 20 == 0) grow = ~grow;
			if (k == RANDOM_ITEMS / 2) wait_list_idle();
			r = $urandom_range(0, 99);
			if (r < 20) begin
				send_op($urandom_range(0, 1) ? FN_DUMP_FWD : FN_DUMP_BWD, $urandom);
			end else if (grow ? (r < 70) : (r < 35)) begin
				send_op(FN_APPEND, pick_value());
			end else begin
				if (list_contents.size() != 0 && $urandom_range(0, 3) != 0)
					val = list_contents[$urandom_range(0, list_contents.size() - 1)];
				else
					val = pick_value();
				send_op(FN_DELETE, val);
			end
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.func  = FN_APPEND;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		error_count  = 0;
		cycle_count  = 0;
		burst_left   = 0;
		stall_left   = 0;
		stall_mode   = 0;
		stall_phase_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_to_capacity();
		test_dump_both_ways();
		test_delete_cases();
		test_random_ops();

		wait_list_idle();
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("ordered_list_append_delete_tb: PASS");
		end else begin
			$display("ordered_list_append_delete_tb: FAIL");
		end
		$finish;
	end

endmodule
